### src/brt_pkg.sv
// ----------------------------------------------------------------------------
// brt_pkg: shared types and tables of the bordered rectangle tessellator
// Holds the corner selector tables for both vertex lists and the word that
// passes from the corner stage to the vertex emitter.
// ----------------------------------------------------------------------------
package brt_pkg;

    localparam int CoordW    = 18;
    localparam int RgbaW     = 32;
    localparam int EdgeW     = 16;
    localparam int WidthW    = 12;
    localparam int VertIdxW  = 5;

    localparam logic [VertIdxW-1:0] FramedLastIdx = VertIdxW'(29);
    localparam logic [VertIdxW-1:0] SolidLastIdx  = VertIdxW'(5);
    localparam logic [VertIdxW-1:0] FillCount     = VertIdxW'(6);

    // Corner selectors: outer low, inner low, inner high, outer high.
    localparam logic [1:0] SelOuterLo = 2'd0;
    localparam logic [1:0] SelInnerLo = 2'd1;
    localparam logic [1:0] SelInnerHi = 2'd2;
    localparam logic [1:0] SelOuterHi = 2'd3;

    localparam logic [1:0] FRAMED_X [0:29] = '{
        SelInnerLo, SelInnerHi, SelInnerHi, SelInnerLo, SelInnerHi, SelInnerLo,
        SelOuterLo, SelInnerLo, SelInnerLo, SelOuterLo, SelInnerLo, SelOuterLo,
        SelOuterLo, SelOuterHi, SelInnerHi, SelOuterLo, SelInnerHi, SelInnerLo,
        SelInnerHi, SelOuterHi, SelOuterHi, SelInnerHi, SelOuterHi, SelInnerHi,
        SelInnerLo, SelInnerHi, SelOuterHi, SelInnerLo, SelOuterHi, SelOuterLo
    };
    localparam logic [1:0] FRAMED_Y [0:29] = '{
        SelInnerLo, SelInnerLo, SelInnerHi, SelInnerLo, SelInnerHi, SelInnerHi,
        SelOuterLo, SelInnerLo, SelInnerHi, SelOuterLo, SelInnerHi, SelOuterHi,
        SelOuterLo, SelOuterLo, SelInnerLo, SelOuterLo, SelInnerLo, SelInnerLo,
        SelInnerLo, SelOuterLo, SelOuterHi, SelInnerLo, SelOuterHi, SelInnerHi,
        SelInnerHi, SelInnerHi, SelOuterHi, SelInnerHi, SelOuterHi, SelOuterHi
    };
    localparam logic [1:0] SOLID_X [0:5] = '{
        SelOuterLo, SelOuterHi, SelOuterHi, SelOuterLo, SelOuterHi, SelOuterLo
    };
    localparam logic [1:0] SOLID_Y [0:5] = '{
        SelOuterLo, SelOuterLo, SelOuterHi, SelOuterLo, SelOuterHi, SelOuterHi
    };

    typedef logic signed [CoordW-1:0] t_coord;

    typedef struct packed {
        t_coord [3:0]       xs;
        t_coord [3:0]       ys;
        logic [RgbaW-1:0]   fill_rgba;
        logic [RgbaW-1:0]   edge_rgba;
        logic               framed;
    } t_item;

endpackage

### src/brt_corner.sv
// ----------------------------------------------------------------------------
// brt_corner: corner stage
// Registers one rectangle word as its four x and four y corner positions at
// doubled scale, together with the colors and the framed/solid decision.
// ----------------------------------------------------------------------------
module brt_corner
    import brt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic signed [EdgeW-1:0]  i_rect_left,
    input  logic signed [EdgeW-1:0]  i_rect_top,
    input  logic signed [EdgeW-1:0]  i_rect_right,
    input  logic signed [EdgeW-1:0]  i_rect_bottom,
    input  logic [RgbaW-1:0]         i_fill_rgba,
    input  logic [RgbaW-1:0]         i_edge_rgba,
    input  logic [WidthW-1:0]        i_edge_width,
    output t_item                    o_item
);

    t_item r_item;
    t_item n_item;

    t_coord                 l2, t2, r2, b2, bw;
    logic signed [EdgeW:0]  w_size, h_size, bw_cmp;

    always_comb begin
        l2 = {i_rect_left[EdgeW-1], i_rect_left, 1'b0};
        t2 = {i_rect_top[EdgeW-1], i_rect_top, 1'b0};
        r2 = {i_rect_right[EdgeW-1], i_rect_right, 1'b0};
        b2 = {i_rect_bottom[EdgeW-1], i_rect_bottom, 1'b0};
        bw = {{(CoordW-WidthW){1'b0}}, i_edge_width};

        w_size = {i_rect_right[EdgeW-1], i_rect_right} - {i_rect_left[EdgeW-1], i_rect_left};
        h_size = {i_rect_bottom[EdgeW-1], i_rect_bottom} - {i_rect_top[EdgeW-1], i_rect_top};
        bw_cmp = {{(EdgeW+1-WidthW){1'b0}}, i_edge_width};

        n_item.xs[SelOuterLo] = l2 - bw;
        n_item.xs[SelInnerLo] = l2 + bw;
        n_item.xs[SelInnerHi] = r2 - bw;
        n_item.xs[SelOuterHi] = r2 + bw;
        n_item.ys[SelOuterLo] = t2 - bw;
        n_item.ys[SelInnerLo] = t2 + bw;
        n_item.ys[SelInnerHi] = b2 - bw;
        n_item.ys[SelOuterHi] = b2 + bw;
        n_item.fill_rgba      = i_fill_rgba;
        n_item.edge_rgba      = i_edge_rgba;
        // Ties go to the solid path.
        n_item.framed         = (w_size > bw_cmp) && (h_size > bw_cmp);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

### src/brt_emit.sv
// ----------------------------------------------------------------------------
// brt_emit: vertex emitter
// Steps through the vertex list of the held rectangle, one vertex per cycle,
// and registers each vertex onto the result ports.
// ----------------------------------------------------------------------------
module brt_emit
    import brt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load,
    input  t_item                    i_item,
    output logic                     o_busy,
    output logic                     o_strobe,
    output logic signed [CoordW-1:0] o_vert_x,
    output logic signed [CoordW-1:0] o_vert_y,
    output logic [RgbaW-1:0]         o_vert_rgba,
    output logic                     o_last_vertex
);

    logic                r_active;
    logic [VertIdxW-1:0] r_idx;
    logic                r_strobe;
    t_coord              r_x, r_y;
    logic [RgbaW-1:0]    r_rgba;
    logic                r_last;

    logic [1:0]          x_sel, y_sel;
    logic [VertIdxW-1:0] last_idx;
    logic                is_last;
    logic [RgbaW-1:0]    rgba;

    always_comb begin
        if (i_item.framed) begin
            x_sel    = FRAMED_X[r_idx];
            y_sel    = FRAMED_Y[r_idx];
            last_idx = FramedLastIdx;
            rgba     = (r_idx < FillCount) ? i_item.fill_rgba : i_item.edge_rgba;
        end else begin
            x_sel    = SOLID_X[r_idx[2:0]];
            y_sel    = SOLID_Y[r_idx[2:0]];
            last_idx = SolidLastIdx;
            rgba     = i_item.edge_rgba;
        end
        is_last = (r_idx == last_idx);
    end

    // A new word may load in the same cycle the last vertex goes out.
    assign o_busy = r_active && !is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (i_load) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (r_active) begin
                if (is_last) begin
                    r_active <= 1'b0;
                end
                r_idx <= r_idx + VertIdxW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_x    <= i_item.xs[x_sel];
            r_y    <= i_item.ys[y_sel];
            r_rgba <= rgba;
            r_last <= is_last;
        end
    end

    assign o_strobe      = r_strobe;
    assign o_vert_x      = r_x;
    assign o_vert_y      = r_y;
    assign o_vert_rgba   = r_rgba;
    assign o_last_vertex = r_last;

endmodule

### src/bordered_rect_tessellator.sv
// ----------------------------------------------------------------------------
// bordered_rect_tessellator: bordered rectangle to triangle-list vertices
// Expands one rectangle word into a fill and border triangle list, or into a
// single outer quad in the border color when the rectangle is too small.
// ----------------------------------------------------------------------------
// A rectangle word is taken when start is high and busy is low. The word is
// held in the corner register and its first vertex is then registered onto
// the result ports, after which one vertex follows per cycle: 30 vertices for
// a framed rectangle, 6 for a solid one. busy drops during the cycle in which
// the last vertex of a word is issued, so words stream with no gap between
// their vertex lists. Each vertex is shown for exactly one cycle with o_strobe
// high; the receiver cannot hold results off.
module bordered_rect_tessellator
    import brt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [EdgeW-1:0]  i_rect_left,
    input  logic signed [EdgeW-1:0]  i_rect_top,
    input  logic signed [EdgeW-1:0]  i_rect_right,
    input  logic signed [EdgeW-1:0]  i_rect_bottom,
    input  logic [RgbaW-1:0]         i_fill_rgba,
    input  logic [RgbaW-1:0]         i_edge_rgba,
    input  logic [WidthW-1:0]        i_edge_width,
    output logic                     o_strobe,
    output logic signed [CoordW-1:0] o_vert_x,
    output logic signed [CoordW-1:0] o_vert_y,
    output logic [RgbaW-1:0]         o_vert_rgba,
    output logic                     o_last_vertex
);

    logic  load;
    t_item item;

    assign load = start && !busy;

    brt_corner u_corner (
        .i_clk         (i_clk),
        .i_load        (load),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_right  (i_rect_right),
        .i_rect_bottom (i_rect_bottom),
        .i_fill_rgba   (i_fill_rgba),
        .i_edge_rgba   (i_edge_rgba),
        .i_edge_width  (i_edge_width),
        .o_item        (item)
    );

    brt_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_item        (item),
        .o_busy        (busy),
        .o_strobe      (o_strobe),
        .o_vert_x      (o_vert_x),
        .o_vert_y      (o_vert_y),
        .o_vert_rgba   (o_vert_rgba),
        .o_last_vertex (o_last_vertex)
    );

endmodule

### src/brt_checker.sv
// ----------------------------------------------------------------------------
// brt_checker: port-level checks of the bordered rectangle tessellator
// Watches the command and result ports for the timing of vertex lists.
// ----------------------------------------------------------------------------
module brt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input logic o_last_vertex
);

    logic accept;

    assign accept = start && !busy;

    // A taken word keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy low right after a word was taken");

    // The first vertex of a word reaches o_strobe through the corner and result registers.
    a_first_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_strobe)
        else $error("no vertex two cycles after a word was taken");

    // A vertex list has no holes before its last vertex.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_vertex) |=> o_strobe)
        else $error("vertex list broke off before its last vertex");

    // The vertex stream only stops after a last vertex.
    a_stop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_strobe) |-> $past(o_last_vertex))
        else $error("vertex stream stopped without a last vertex");

endmodule

bind bordered_rect_tessellator brt_checker u_brt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_last_vertex (o_last_vertex)
);

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bordered rectangle tessellator
// Feeds rectangle words through the start/busy handshake and predicts the
// vertex list of each one: corner rectangles first, then random rectangles
// under sparse, dense and no sender gaps. Every strobed vertex is compared
// field by field against the oldest predicted vertex still waiting.
// ----------------------------------------------------------------------------
module tb;
    import brt_pkg::*;

    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 8;

    typedef struct {
        logic signed [EdgeW-1:0] left;
        logic signed [EdgeW-1:0] top;
        logic signed [EdgeW-1:0] right;
        logic signed [EdgeW-1:0] bottom;
        logic [RgbaW-1:0]        fill;
        logic [RgbaW-1:0]        border;
        logic [WidthW-1:0]       width;
    } rect_word_t;

    typedef struct {
        t_coord            x;
        t_coord            y;
        logic [RgbaW-1:0]  rgba;
        logic              last;
    } vertex_t;

    // Corner picks for the framed list: fill, then left, top, right, bottom quads.
    localparam logic [1:0] FRAME_X_SEL [0:29] = '{
        SelInnerLo, SelInnerHi, SelInnerHi, SelInnerLo, SelInnerHi, SelInnerLo,
        SelOuterLo, SelInnerLo, SelInnerLo, SelOuterLo, SelInnerLo, SelOuterLo,
        SelOuterLo, SelOuterHi, SelInnerHi, SelOuterLo, SelInnerHi, SelInnerLo,
        SelInnerHi, SelOuterHi, SelOuterHi, SelInnerHi, SelOuterHi, SelInnerHi,
        SelInnerLo, SelInnerHi, SelOuterHi, SelInnerLo, SelOuterHi, SelOuterLo
    };
    localparam logic [1:0] FRAME_Y_SEL [0:29] = '{
        SelInnerLo, SelInnerLo, SelInnerHi, SelInnerLo, SelInnerHi, SelInnerHi,
        SelOuterLo, SelInnerLo, SelInnerHi, SelOuterLo, SelInnerHi, SelOuterHi,
        SelOuterLo, SelOuterLo, SelInnerLo, SelOuterLo, SelInnerLo, SelInnerLo,
        SelInnerLo, SelOuterLo, SelOuterHi, SelInnerLo, SelOuterHi, SelInnerHi,
        SelInnerHi, SelInnerHi, SelOuterHi, SelInnerHi, SelOuterHi, SelOuterHi
    };
    localparam logic [1:0] QUAD_X_SEL [0:5] = '{
        SelOuterLo, SelOuterHi, SelOuterHi, SelOuterLo, SelOuterHi, SelOuterLo
    };
    localparam logic [1:0] QUAD_Y_SEL [0:5] = '{
        SelOuterLo, SelOuterLo, SelOuterHi, SelOuterLo, SelOuterHi, SelOuterHi
    };

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [EdgeW-1:0]  i_rect_left;
    logic signed [EdgeW-1:0]  i_rect_top;
    logic signed [EdgeW-1:0]  i_rect_right;
    logic signed [EdgeW-1:0]  i_rect_bottom;
    logic [RgbaW-1:0]         i_fill_rgba;
    logic [RgbaW-1:0]         i_edge_rgba;
    logic [WidthW-1:0]        i_edge_width;
    logic                     o_strobe;
    logic signed [CoordW-1:0] o_vert_x;
    logic signed [CoordW-1:0] o_vert_y;
    logic [RgbaW-1:0]         o_vert_rgba;
    logic                     o_last_vertex;

    vertex_t pending_vertices [$];
    int      errors;
    int      stalled_cycles;

    bordered_rect_tessellator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_rect_left   (i_rect_left),
        .i_rect_top    (i_rect_top),
        .i_rect_right  (i_rect_right),
        .i_rect_bottom (i_rect_bottom),
        .i_fill_rgba   (i_fill_rgba),
        .i_edge_rgba   (i_edge_rgba),
        .i_edge_width  (i_edge_width),
        .o_strobe      (o_strobe),
        .o_vert_x      (o_vert_x),
        .o_vert_y      (o_vert_y),
        .o_vert_rgba   (o_vert_rgba),
        .o_last_vertex (o_last_vertex)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Works out the vertex list of one rectangle word and queues it.
    function automatic void tessellate_rect(input rect_word_t w);
        int      xs [4];
        int      ys [4];
        int      bw;
        bit      framed;
        vertex_t v;
        bw    = int'(w.width);
        xs[0] = 2 * int'(w.left) - bw;
        xs[1] = 2 * int'(w.left) + bw;
        xs[2] = 2 * int'(w.right) - bw;
        xs[3] = 2 * int'(w.right) + bw;
        ys[0] = 2 * int'(w.top) - bw;
        ys[1] = 2 * int'(w.top) + bw;
        ys[2] = 2 * int'(w.bottom) - bw;
        ys[3] = 2 * int'(w.bottom) + bw;
        framed = (int'(w.right) - int'(w.left) > bw) && (int'(w.bottom) - int'(w.top) > bw);
        if (framed) begin
            for (int k = 0; k < 30; k++) begin
                v.x    = t_coord'(xs[FRAME_X_SEL[k]]);
                v.y    = t_coord'(ys[FRAME_Y_SEL[k]]);
                v.rgba = (k < 6) ? w.fill : w.border;
                v.last = (k == 29);
                pending_vertices.push_back(v);
            end
        end else begin
            for (int k = 0; k < 6; k++) begin
                v.x    = t_coord'(xs[QUAD_X_SEL[k]]);
                v.y    = t_coord'(ys[QUAD_Y_SEL[k]]);
                v.rgba = w.border;
                v.last = (k == 5);
                pending_vertices.push_back(v);
            end
        end
    endfunction

    function automatic rect_word_t make_rect(input int l, input int t, input int r,
                                             input int b, input logic [RgbaW-1:0] fill,
                                             input logic [RgbaW-1:0] border, input int bw);
        rect_word_t w;
        w.left   = EdgeW'(l);
        w.top    = EdgeW'(t);
        w.right  = EdgeW'(r);
        w.bottom = EdgeW'(b);
        w.fill   = fill;
        w.border = border;
        w.width  = WidthW'(bw);
        return w;
    endfunction

    // Places an interval of the given signed span inside the 16-bit edge range.
    function automatic void place_span(input int span, output int lo, output int hi);
        if (span >= 0) begin
            lo = int'($urandom_range(0, 65535 - span)) - 32768;
            hi = lo + span;
        end else begin
            hi = int'($urandom_range(0, 65535 + span)) - 32768;
            lo = hi - span;
        end
    endfunction

    // Mostly framed rectangles with random content; the rest ties, inversions,
    // undersized rectangles and raw noise.
    function automatic rect_word_t random_rect();
        int bw;
        int mode;
        int span_x;
        int span_y;
        int l, t, r, b;
        bw     = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095))
                                             : int'($urandom_range(0, 63));
        mode   = $urandom_range(0, 9);
        span_x = bw + 1 + int'($urandom_range(0, 4000));
        span_y = bw + 1 + int'($urandom_range(0, 4000));
        case (mode)
            6: begin
                if ($urandom_range(0, 1)) span_x = bw;
                else span_y = bw;
            end
            7: begin
                if ($urandom_range(0, 1)) span_x = -int'($urandom_range(1, 5000));
                else span_y = -int'($urandom_range(1, 5000));
            end
            9: begin
                span_x = $urandom_range(0, bw);
                span_y = $urandom_range(0, bw);
            end
            default: ;
        endcase
        place_span(span_x, l, r);
        place_span(span_y, t, b);
        if (mode == 8) begin
            l = $urandom();
            t = $urandom();
            r = $urandom();
            b = $urandom();
        end
        return make_rect(l, t, r, b, $urandom(), $urandom(), bw);
    endfunction

    // Presents one rectangle word after random idle cycles and waits until taken.
    task automatic send_rect(input rect_word_t w, input int idle_pct);
        while (int'($urandom_range(0, 99)) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_rect_left   <= w.left;
        i_rect_top    <= w.top;
        i_rect_right  <= w.right;
        i_rect_bottom <= w.bottom;
        i_fill_rgba   <= w.fill;
        i_edge_rgba   <= w.border;
        i_edge_width  <= w.width;
        do @(posedge i_clk); while (busy);
        tessellate_rect(w);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_rects(input int count, input int idle_pct);
        for (int n = 0; n < count; n++) send_rect(random_rect(), idle_pct);
    endtask

    task automatic test_corner_rects();
        // Rectangles collapsed onto the most negative and most positive edge.
        send_rect(make_rect(-32768, -32768, -32768, -32768, '0, '0, 0), 0);
        send_rect(make_rect(32767, 32767, 32767, 32767, '1, '1, 4095), 0);
        // Full span with the widest border, then with no border at all, then inverted.
        send_rect(make_rect(-32768, -32768, 32767, 32767, 32'hFFFF_FFFF, 32'h0, 4095), 0);
        send_rect(make_rect(-32768, -32768, 32767, 32767, 32'h0, 32'hFFFF_FFFF, 0), 0);
        send_rect(make_rect(32767, -32768, -32768, 32767, 32'h5555_5555, 32'hAAAA_AAAA, 0), 0);
        // Size equal to the border width takes the solid path on either axis.
        send_rect(make_rect(100, 0, 116, 200, 32'hAAAA_AAAA, 32'h5555_5555, 16), 0);
        send_rect(make_rect(0, -50, 300, -34, 32'h1234_5678, 32'h8765_4321, 16), 0);
        // One above the width on both axes is framed.
        send_rect(make_rect(-10, -10, 7, 7, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 16), 0);
        send_rect(make_rect(-2048, -2048, 2048, 2048, 32'hDEAD_BEEF, 32'hCAFE_F00D, 4095), 0);
        // Inverted horizontally, inverted vertically.
        send_rect(make_rect(500, 0, -500, 900, 32'h0000_00FF, 32'hFF00_0000, 8), 0);
        send_rect(make_rect(0, 700, 900, -700, 32'h00FF_0000, 32'h0000_FF00, 8), 0);
        // Zero border on a one-unit and a zero-width rectangle: border quads of no area.
        send_rect(make_rect(3, 4, 4, 5, 32'h8000_0001, 32'h7FFF_FFFE, 0), 0);
        send_rect(make_rect(3, 4, 3, 5, 32'h8000_0001, 32'h7FFF_FFFE, 0), 0);
        send_rect(make_rect(-32768, 32767, 32767, -32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2730), 0);
    endtask

    task automatic test_sparse_gaps();
        send_random_rects(90, 6);
    endtask

    task automatic test_dense_gaps();
        send_random_rects(45, 81);
        // Let the whole backlog of vertices out before the next word.
        wait_drained();
        send_random_rects(45, 81);
    endtask

    task automatic test_back_to_back();
        send_random_rects(90, 0);
    endtask

    always @(posedge i_clk) begin
        vertex_t want;
        if (i_rst_n && o_strobe) begin
            if (pending_vertices.size() == 0) begin
                $display("%0t: vertex with none expected, got x %0d y %0d rgba %h last %b",
                         $time, o_vert_x, o_vert_y, o_vert_rgba, o_last_vertex);
                errors++;
            end else begin
                want = pending_vertices.pop_front();
                if (o_vert_x !== want.x) begin
                    $display("%0t: vert_x expected %0d, got %0d", $time, want.x, o_vert_x);
                    errors++;
                end
                if (o_vert_y !== want.y) begin
                    $display("%0t: vert_y expected %0d, got %0d", $time, want.y, o_vert_y);
                    errors++;
                end
                if (o_vert_rgba !== want.rgba) begin
                    $display("%0t: vert_rgba expected %h, got %h", $time, want.rgba,
                             o_vert_rgba);
                    errors++;
                end
                if (o_last_vertex !== want.last) begin
                    $display("%0t: last_vertex expected %b, got %b", $time, want.last,
                             o_last_vertex);
                    errors++;
                end
            end
        end
    end

    // A cycle counts as stalled when no word is taken and no vertex leaves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= WatchdogLimit) begin
            $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        errors         = 0;
        stalled_cycles = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_rect_left    = '0;
        i_rect_top     = '0;
        i_rect_right   = '0;
        i_rect_bottom  = '0;
        i_fill_rgba    = '0;
        i_edge_rgba    = '0;
        i_edge_width   = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_corner_rects();
        test_sparse_gaps();
        test_dense_gaps();
        test_back_to_back();

        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0 && pending_vertices.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### files.f
src/brt_pkg.sv
src/brt_corner.sv
src/brt_emit.sv
src/bordered_rect_tessellator.sv
src/brt_checker.sv
tb/sv/tb.sv
